FILE: design/multi_axis_bin_index_defines.svh
// ----------------------------------------------------------------------------
// multi_axis_bin_index assertion macros
// Shared concurrent assertion helpers, clocked on clk_i and held off in reset.
// ----------------------------------------------------------------------------
`ifndef MULTI_AXIS_BIN_INDEX_DEFINES_SVH
`define MULTI_AXIS_BIN_INDEX_DEFINES_SVH

// same-cycle implication
`define MABI_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define MABI_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: design/mabi_pkg.sv
// ----------------------------------------------------------------------------
// mabi_pkg
// Types, constants and helpers shared by the bin lookup pipeline.
// ----------------------------------------------------------------------------
package mabi_pkg;

  localparam int unsigned MaxAxes   = 3;
  localparam int unsigned MaxBins   = 64;
  localparam int unsigned Slots     = MaxBins + 1;
  localparam int unsigned CoordBits = 32;
  localparam int unsigned SlotW     = 7;
  localparam int unsigned CntW      = 7;
  localparam int unsigned BinW      = 6;
  localparam int unsigned PartW     = 12;
  localparam int unsigned IdxW      = 18;
  localparam int unsigned AxisW     = 2;
  localparam int unsigned CfgIdxW   = 3;
  localparam int unsigned CfgDataW  = 7;

  typedef enum logic [0:0] {
    OP_LOAD   = 1'b0,
    OP_LOOKUP = 1'b1
  } opcode_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_UNDER = 2'd1,
    ST_OVER  = 2'd2
  } status_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_FLOW_MODE = 3'd0,
    CFG_EDGE_RULE = 3'd1,
    CFG_NUM_AXES  = 3'd2,
    CFG_BINS_AX0  = 3'd3,
    CFG_BINS_AX1  = 3'd4,
    CFG_BINS_AX2  = 3'd5
  } cfg_idx_e;

  // per-axis compare vectors against every edge slot
  typedef struct packed {
    logic [Slots-1:0] ge;
    logic [Slots-1:0] eq;
  } cmp_t;

  typedef struct packed {
    logic clamp_under;
    logic clamp_over;
    logic rule_upper;
  } flow_ctl_t;

  typedef struct packed {
    status_e         st;
    logic [BinW-1:0] bin;
  } axis_res_t;

  // bin count held to 1..MaxBins
  function automatic logic [CntW-1:0] eff_bins(input logic [CfgDataW-1:0] raw);
    logic [CntW-1:0] nb;
    nb = raw;
    if (nb == '0) begin
      nb = CntW'(1);
    end else if (nb > CntW'(MaxBins)) begin
      nb = CntW'(MaxBins);
    end
    return nb;
  endfunction

endpackage

FILE: design/multi_axis_bin_index.sv
// ----------------------------------------------------------------------------
// multi_axis_bin_index
// Multidimensional histogram bin lookup over loaded non-uniform edges.
// ----------------------------------------------------------------------------
// Throughput: one request per cycle, lookup or edge load; busy_o stays low.
// Five register stages: input, edge compare bank, bin select, two multiplies.
// Reset clears the configuration to its defaults and all pipeline valids;
// the edge table is not cleared and must be loaded before lookups use it.
`include "multi_axis_bin_index_defines.svh"

module multi_axis_bin_index
  import mabi_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  output logic                  busy_o,
  input  logic                  opcode_i,
  input  logic [AxisW-1:0]      axis_sel_i,
  input  logic [SlotW-1:0]      edge_slot_i,
  input  logic [CoordBits-1:0]  edge_value_i,
  input  logic [CoordBits-1:0]  coord_x_i,
  input  logic [CoordBits-1:0]  coord_y_i,
  input  logic [CoordBits-1:0]  coord_z_i,
  input  logic                  cfg_we_i,
  input  logic [CfgIdxW-1:0]    cfg_idx_i,
  input  logic [CfgDataW-1:0]   cfg_wdata_i,
  output logic                  valid_o,
  output logic [IdxW-1:0]       flat_index_o,
  output logic [1:0]            status_o,
  output logic [AxisW-1:0]      fault_axis_o
);

  logic [1:0]                    flow_mode_q;
  logic                          edge_rule_q;
  logic [1:0]                    num_axes_q;
  logic [MaxAxes-1:0][CntW-1:0]  bins_q;

  logic [MaxAxes-1:0][CntW-1:0]  nbins;
  logic [AxisW-1:0]              naxes;
  flow_ctl_t                     flow;

  logic                          accept;
  logic                          look_q, load_q;
  logic [AxisW-1:0]              axis_q;
  logic [SlotW-1:0]              slot_q;
  logic [CoordBits-1:0]          value_q;
  logic [MaxAxes-1:0][CoordBits-1:0] coord_q;

  logic                          cmp_valid;
  cmp_t [MaxAxes-1:0]            cmp;
  logic                          sel_valid;
  axis_res_t [MaxAxes-1:0]       res;
  status_e                       status;

  assign busy_o = 1'b0;
  assign accept = start_i && !busy_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flow_mode_q <= 2'd0;
      edge_rule_q <= 1'b0;
      num_axes_q  <= 2'd1;
      bins_q      <= {MaxAxes{CntW'(1)}};
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_FLOW_MODE: flow_mode_q <= cfg_wdata_i[1:0];
        CFG_EDGE_RULE: edge_rule_q <= cfg_wdata_i[0];
        CFG_NUM_AXES:  num_axes_q  <= cfg_wdata_i[1:0];
        CFG_BINS_AX0:  bins_q[0]   <= cfg_wdata_i;
        CFG_BINS_AX1:  bins_q[1]   <= cfg_wdata_i;
        CFG_BINS_AX2:  bins_q[2]   <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    for (int a = 0; a < MaxAxes; a++) begin
      nbins[a] = eff_bins(bins_q[a]);
    end
  end

  assign naxes            = (num_axes_q == 2'd0) ? AxisW'(1) : num_axes_q;
  assign flow.clamp_under = flow_mode_q[0];
  assign flow.clamp_over  = flow_mode_q[1];
  assign flow.rule_upper  = edge_rule_q;

  // input request register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      look_q <= 1'b0;
      load_q <= 1'b0;
    end else begin
      look_q <= accept && (opcode_i == OP_LOOKUP);
      load_q <= accept && (opcode_i == OP_LOAD);
    end
  end

  always_ff @(posedge clk_i) begin
    axis_q     <= axis_sel_i;
    slot_q     <= edge_slot_i;
    value_q    <= edge_value_i;
    coord_q[0] <= coord_x_i;
    coord_q[1] <= coord_y_i;
    coord_q[2] <= coord_z_i;
  end

  mabi_edge_bank u_edge_bank (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .load_en_i    (load_q),
    .load_axis_i  (axis_q),
    .load_slot_i  (slot_q),
    .load_value_i (value_q),
    .look_valid_i (look_q),
    .coord_i      (coord_q),
    .nbins_i      (nbins),
    .look_valid_o (cmp_valid),
    .cmp_o        (cmp)
  );

  mabi_bin_sel u_bin_sel (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (cmp_valid),
    .cmp_i   (cmp),
    .nbins_i (nbins),
    .flow_i  (flow),
    .valid_o (sel_valid),
    .res_o   (res)
  );

  mabi_combine u_combine (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .valid_i      (sel_valid),
    .res_i        (res),
    .nbins_i      (nbins),
    .naxes_i      (naxes),
    .valid_o      (valid_o),
    .flat_index_o (flat_index_o),
    .status_o     (status),
    .fault_axis_o (fault_axis_o)
  );

  assign status_o = status;

  `MABI_ASSERT_IMP(a_result_has_lookup, valid_o,
    $past(start_i && !busy_o && (opcode_i == OP_LOOKUP), 5), "result without a lookup request")
  `MABI_ASSERT_IMP(a_fault_zero_index, valid_o && (status_o != ST_OK),
    flat_index_o == '0, "faulted result carries a non-zero index")
  `MABI_ASSERT_IMP(a_ok_zero_axis, valid_o && (status_o == ST_OK),
    fault_axis_o == '0, "ok result names a fault axis")
  `MABI_ASSERT_NXT(a_load_no_result, look_q == 1'b0 && load_q == 1'b1,
    cmp_valid == 1'b0, "edge load produced a compare result")

endmodule

FILE: design/mabi_edge_bank.sv
// ----------------------------------------------------------------------------
// mabi_edge_bank
// Edge register table with a ge and an eq comparator per slot; registers the compare
// vectors of every axis for the next stage.
// ----------------------------------------------------------------------------
module mabi_edge_bank
  import mabi_pkg::*;
(
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                load_en_i,
  input  logic [AxisW-1:0]                    load_axis_i,
  input  logic [SlotW-1:0]                    load_slot_i,
  input  logic [CoordBits-1:0]                load_value_i,
  input  logic                                look_valid_i,
  input  logic [MaxAxes-1:0][CoordBits-1:0]   coord_i,
  input  logic [MaxAxes-1:0][CntW-1:0]        nbins_i,
  output logic                                look_valid_o,
  output cmp_t [MaxAxes-1:0]                  cmp_o
);

  logic [CoordBits-1:0] edge_q [MaxAxes][Slots];
  cmp_t [MaxAxes-1:0]   cmp_d, cmp_q;
  logic                 valid_q;

  // edge table has no reset; the user must load entries before lookups read them, the block does not enforce it
  always_ff @(posedge clk_i) begin
    if (load_en_i && (load_axis_i < AxisW'(MaxAxes)) && (load_slot_i <= SlotW'(MaxBins))) begin
      edge_q[load_axis_i][load_slot_i] <= load_value_i;
    end
  end

  always_comb begin
    for (int a = 0; a < MaxAxes; a++) begin
      for (int k = 0; k < Slots; k++) begin
        // slots beyond the bin count never take part in the search
        cmp_d[a].ge[k] = ($signed(edge_q[a][k]) >= $signed(coord_i[a]))
                         && (SlotW'(k) <= nbins_i[a]);
        cmp_d[a].eq[k] = (edge_q[a][k] == coord_i[a]);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= look_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    cmp_q <= cmp_d;
  end

  assign look_valid_o = valid_q;
  assign cmp_o        = cmp_q;

endmodule

FILE: design/mabi_bin_sel.sv
// ----------------------------------------------------------------------------
// mabi_bin_sel
// Picks the first edge not below the coordinate on each axis and turns it
// into a bin, applying the edge rule and the flow mode.
// ----------------------------------------------------------------------------
module mabi_bin_sel
  import mabi_pkg::*;
(
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          valid_i,
  input  cmp_t [MaxAxes-1:0]            cmp_i,
  input  logic [MaxAxes-1:0][CntW-1:0]  nbins_i,
  input  flow_ctl_t                     flow_i,
  output logic                          valid_o,
  output axis_res_t [MaxAxes-1:0]       res_o
);

  axis_res_t [MaxAxes-1:0] res_d, res_q;
  logic                    valid_q;

  always_comb begin
    logic [Slots-1:0] low;
    logic [SlotW-1:0] idx;
    logic [BinW-1:0]  last;
    logic             hit;
    logic             under;
    logic             found;
    for (int a = 0; a < MaxAxes; a++) begin
      // isolate the lowest set bit
      low   = cmp_i[a].ge & (~cmp_i[a].ge + Slots'(1));
      idx   = '0;
      for (int k = 0; k < Slots; k++) begin
        idx = idx | (low[k] ? SlotW'(k) : SlotW'(0));
      end
      hit   = |(low & cmp_i[a].eq);
      under = cmp_i[a].ge[0] & ~cmp_i[a].eq[0];
      found = |cmp_i[a].ge;
      last  = BinW'(nbins_i[a] - CntW'(1));

      res_d[a].st  = ST_OK;
      res_d[a].bin = '0;
      priority if (under) begin
        if (!flow_i.clamp_under) begin
          res_d[a].st = ST_UNDER;
        end
      end else if (!found) begin
        if (flow_i.clamp_over) begin
          res_d[a].bin = last;
        end else begin
          res_d[a].st = ST_OVER;
        end
      end else if (hit && flow_i.rule_upper) begin
        res_d[a].bin = (idx >= nbins_i[a]) ? last : idx[BinW-1:0];
      end else begin
        res_d[a].bin = (idx == '0) ? BinW'(0) : BinW'(idx - SlotW'(1));
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign valid_o = valid_q;
  assign res_o   = res_q;

endmodule

FILE: design/mabi_combine.sv
// ----------------------------------------------------------------------------
// mabi_combine
// Resolves the reported fault and folds the per-axis bins row-major into the
// flat index over two multiply stages.
// ----------------------------------------------------------------------------
module mabi_combine
  import mabi_pkg::*;
(
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          valid_i,
  input  axis_res_t [MaxAxes-1:0]       res_i,
  input  logic [MaxAxes-1:0][CntW-1:0]  nbins_i,
  input  logic [AxisW-1:0]              naxes_i,
  output logic                          valid_o,
  output logic [IdxW-1:0]               flat_index_o,
  output status_e                       status_o,
  output logic [AxisW-1:0]              fault_axis_o
);

  // stage one: first product and fault pick
  logic               p_valid_q;
  logic [PartW-1:0]   part_d, part_q;
  logic [BinW-1:0]    bin2_q;
  logic               use3_q;
  status_e            fst_d, fst_q;
  logic [AxisW-1:0]   fax_d, fax_q;

  // stage two: result register
  logic               o_valid_q;
  logic [IdxW-1:0]    flat_d, flat_q;
  status_e            ost_q;
  logic [AxisW-1:0]   oax_q;

  always_comb begin
    logic [PartW:0] prod;
    fst_d = ST_OK;
    fax_d = '0;
    // walk down so the lowest faulting axis wins
    for (int a = MaxAxes - 1; a >= 0; a--) begin
      if ((AxisW'(a) < naxes_i) && (res_i[a].st != ST_OK)) begin
        fst_d = res_i[a].st;
        fax_d = AxisW'(a);
      end
    end
    prod = (PartW+1)'(res_i[0].bin) * (PartW+1)'(nbins_i[1]) + (PartW+1)'(res_i[1].bin);
    part_d = (naxes_i >= AxisW'(2)) ? prod[PartW-1:0] : PartW'(res_i[0].bin);
  end

  always_comb begin
    logic [IdxW:0] full;
    full   = (IdxW+1)'(part_q) * (IdxW+1)'(nbins_i[2]) + (IdxW+1)'(bin2_q);
    flat_d = use3_q ? full[IdxW-1:0] : IdxW'(part_q);
    if (fst_q != ST_OK) begin
      flat_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_valid_q <= 1'b0;
      o_valid_q <= 1'b0;
    end else begin
      p_valid_q <= valid_i;
      o_valid_q <= p_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    part_q <= part_d;
    bin2_q <= res_i[2].bin;
    use3_q <= (naxes_i == AxisW'(3));
    fst_q  <= fst_d;
    fax_q  <= fax_d;
    flat_q <= flat_d;
    ost_q  <= fst_q;
    oax_q  <= fax_q;
  end

  assign valid_o      = o_valid_q;
  assign flat_index_o = flat_q;
  assign status_o     = ost_q;
  assign fault_axis_o = oax_q;

endmodule

FILE: verif/mabi_bin_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// mabi_bin_checker
// Watches the request, configuration and result ports of the bin lookup,
// keeps its own edge table and register copy, predicts each lookup's bin and
// status, and compares every result in order against the oldest prediction.
// ----------------------------------------------------------------------------
module mabi_bin_checker
  import mabi_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic                 busy_o,
  input  logic                 opcode_i,
  input  logic [AxisW-1:0]     axis_sel_i,
  input  logic [SlotW-1:0]     edge_slot_i,
  input  logic [CoordBits-1:0] edge_value_i,
  input  logic [CoordBits-1:0] coord_x_i,
  input  logic [CoordBits-1:0] coord_y_i,
  input  logic [CoordBits-1:0] coord_z_i,
  input  logic                 cfg_we_i,
  input  logic [CfgIdxW-1:0]   cfg_idx_i,
  input  logic [CfgDataW-1:0]  cfg_wdata_i,
  input  logic                 valid_o,
  input  logic [IdxW-1:0]      flat_index_o,
  input  logic [1:0]           status_o,
  input  logic [AxisW-1:0]     fault_axis_o,
  output int unsigned          fail_count_o,
  output int unsigned          pending_o
);

  typedef struct packed {
    logic [IdxW-1:0]  flat;
    status_e          st;
    logic [AxisW-1:0] axis;
  } bin_result_t;

  logic signed [CoordBits-1:0] edge_tab [MaxAxes][Slots];
  logic [1:0]                  flow_q;
  logic                        rule_upper_q;
  logic [1:0]                  axes_q;
  logic [CfgDataW-1:0]         bins_q [MaxAxes];
  bin_result_t                 bin_results_q [$];

  function automatic int bins_in_use(input int ax);
    if (bins_q[ax] == '0) return 1;
    if (bins_q[ax] > MaxBins) return MaxBins;
    return int'(bins_q[ax]);
  endfunction

  // first edge not below the coordinate, then edge rule and flow handling
  function automatic status_e locate_bin(input int ax, input logic signed [CoordBits-1:0] c,
                                         output int bin);
    int nb;
    int k;
    nb  = bins_in_use(ax);
    bin = 0;
    if (c < edge_tab[ax][0]) return flow_q[0] ? ST_OK : ST_UNDER;
    k = 0;
    while (k <= nb && edge_tab[ax][k] < c) k++;
    if (k > nb) begin
      if (!flow_q[1]) return ST_OVER;
      bin = nb - 1;
      return ST_OK;
    end
    if (edge_tab[ax][k] == c && rule_upper_q) bin = (k >= nb) ? nb - 1 : k;
    else bin = (k == 0) ? 0 : k - 1;
    return ST_OK;
  endfunction

  function automatic bin_result_t predict_lookup(input logic [CoordBits-1:0] x,
                                                 input logic [CoordBits-1:0] y,
                                                 input logic [CoordBits-1:0] z);
    logic signed [CoordBits-1:0] crd [MaxAxes];
    int          n;
    int          bin;
    int unsigned flat;
    status_e     st;
    bin_result_t r;
    crd[0] = x;
    crd[1] = y;
    crd[2] = z;
    n      = (axes_q == '0) ? 1 : int'(axes_q);
    flat   = 0;
    r.flat = '0;
    r.st   = ST_OK;
    r.axis = '0;
    for (int a = 0; a < n; a++) begin
      st = locate_bin(a, crd[a], bin);
      if (st != ST_OK) begin
        r.st   = st;
        r.axis = AxisW'(a);
        return r;
      end
      flat = flat * bins_in_use(a) + bin;
    end
    r.flat = IdxW'(flat);
    return r;
  endfunction

  task automatic report(input string what, input bin_result_t want, input bin_result_t got);
    fail_count_o++;
    if (fail_count_o <= 10) begin
      $display("%0t: %s: expected flat %0d status %0d axis %0d, got flat %0d status %0d axis %0d",
               $time, what, want.flat, want.st, want.axis, got.flat, got.st, got.axis);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    bin_result_t want;
    bin_result_t got;
    if (!rst_ni) begin
      flow_q       = '0;
      rule_upper_q = 1'b0;
      axes_q       = 2'd1;
      for (int a = 0; a < MaxAxes; a++) bins_q[a] = CfgDataW'(1);
      bin_results_q.delete();
    end else begin
      // retire first, a lookup accepted on this edge is younger
      if (valid_o) begin
        got = '{flat: flat_index_o, st: status_e'(status_o), axis: fault_axis_o};
        if (bin_results_q.size() == 0) begin
          want = '{flat: '0, st: ST_OK, axis: '0};
          report("result with no lookup outstanding", want, got);
        end else begin
          want = bin_results_q.pop_front();
          if (got !== want) report("lookup mismatch", want, got);
        end
      end
      if (cfg_we_i) begin
        case (cfg_idx_e'(cfg_idx_i))
          CFG_FLOW_MODE: flow_q       = cfg_wdata_i[1:0];
          CFG_EDGE_RULE: rule_upper_q = cfg_wdata_i[0];
          CFG_NUM_AXES:  axes_q       = cfg_wdata_i[1:0];
          CFG_BINS_AX0:  bins_q[0]    = cfg_wdata_i;
          CFG_BINS_AX1:  bins_q[1]    = cfg_wdata_i;
          CFG_BINS_AX2:  bins_q[2]    = cfg_wdata_i;
          default: ;
        endcase
      end
      if (start_i && !busy_o) begin
        if (opcode_e'(opcode_i) == OP_LOOKUP) begin
          bin_results_q = {bin_results_q, predict_lookup(coord_x_i, coord_y_i, coord_z_i)};
        end else if (axis_sel_i < MaxAxes && edge_slot_i <= MaxBins) begin
          edge_tab[axis_sel_i][edge_slot_i] = edge_value_i;
        end
      end
    end
    pending_o = bin_results_q.size();
  end

endmodule

FILE: verif/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Drives edge loads, lookups and register writes into the bin lookup under
// several flow modes, edge rules and bin counts with random sender gaps;
// the checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module tb;
  import mabi_pkg::*;

  localparam int          NumPhases   = 12;
  localparam int          PhaseItems  = 75;
  localparam int          DrainCycles = 8;
  localparam int unsigned StallLimit  = 2000;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 start_i;
  logic                 busy_o;
  logic                 opcode_i;
  logic [AxisW-1:0]     axis_sel_i;
  logic [SlotW-1:0]     edge_slot_i;
  logic [CoordBits-1:0] edge_value_i;
  logic [CoordBits-1:0] coord_x_i;
  logic [CoordBits-1:0] coord_y_i;
  logic [CoordBits-1:0] coord_z_i;
  logic                 cfg_we_i;
  logic [CfgIdxW-1:0]   cfg_idx_i;
  logic [CfgDataW-1:0]  cfg_wdata_i;
  logic                 valid_o;
  logic [IdxW-1:0]      flat_index_o;
  logic [1:0]           status_o;
  logic [AxisW-1:0]     fault_axis_o;

  int unsigned mismatches;
  int unsigned outstanding;
  int unsigned stall_cycles;
  int          idle_pct;

  // stimulus-side copy of loaded edges and bin counts, used to aim coordinates
  logic signed [CoordBits-1:0] edge_mem [MaxAxes][Slots];
  logic [CfgDataW-1:0]         bins_set [MaxAxes];

  multi_axis_bin_index u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start_i),
    .busy_o       (busy_o),
    .opcode_i     (opcode_i),
    .axis_sel_i   (axis_sel_i),
    .edge_slot_i  (edge_slot_i),
    .edge_value_i (edge_value_i),
    .coord_x_i    (coord_x_i),
    .coord_y_i    (coord_y_i),
    .coord_z_i    (coord_z_i),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .valid_o      (valid_o),
    .flat_index_o (flat_index_o),
    .status_o     (status_o),
    .fault_axis_o (fault_axis_o)
  );

  mabi_bin_checker u_check (
    .fail_count_o (mismatches),
    .pending_o    (outstanding),
    .*
  );

  initial clk_i = 1'b0;
  always #4 clk_i = ~clk_i;

  // cycles with no request, result or register write
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stall_cycles <= 0;
    end else if ((start_i && !busy_o) || valid_o || cfg_we_i) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin : watchdog
    wait (stall_cycles >= StallLimit);
    $display("FAIL");
    $finish;
  end

  task automatic issue(input opcode_e op, input int ax, input int slot,
                       input logic [CoordBits-1:0] ev, input logic [CoordBits-1:0] x,
                       input logic [CoordBits-1:0] y, input logic [CoordBits-1:0] z);
    while ($urandom_range(99) < idle_pct) begin
      @(negedge clk_i);
      start_i <= 1'b0;
    end
    @(negedge clk_i);
    start_i      <= 1'b1;
    opcode_i     <= op;
    axis_sel_i   <= AxisW'(ax);
    edge_slot_i  <= SlotW'(slot);
    edge_value_i <= ev;
    coord_x_i    <= x;
    coord_y_i    <= y;
    coord_z_i    <= z;
    do @(posedge clk_i); while (busy_o);
    if (op == OP_LOAD && ax < MaxAxes && slot <= MaxBins) edge_mem[ax][slot] = ev;
  endtask

  task automatic drain();
    @(negedge clk_i);
    start_i <= 1'b0;
    while (outstanding != 0) @(negedge clk_i);
    // loads give no result and may still be in flight
    repeat (DrainCycles) @(negedge clk_i);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [CfgDataW-1:0] val);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
  endtask

  task automatic set_config(input int flow, input int rule, input int axes,
                            input int b0, input int b1, input int b2);
    drain();
    write_reg(CFG_FLOW_MODE, CfgDataW'(flow));
    write_reg(CFG_EDGE_RULE, CfgDataW'(rule));
    write_reg(CFG_NUM_AXES, CfgDataW'(axes));
    write_reg(CFG_BINS_AX0, CfgDataW'(b0));
    write_reg(CFG_BINS_AX1, CfgDataW'(b1));
    write_reg(CFG_BINS_AX2, CfgDataW'(b2));
    bins_set[0] = CfgDataW'(b0);
    bins_set[1] = CfgDataW'(b1);
    bins_set[2] = CfgDataW'(b2);
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // ascending non-uniform edges, with the odd repeated edge
  task automatic fill_axis(input int ax, input bit wide);
    longint v;
    longint step_max;
    if (wide) begin
      v        = -64'sd2147483648;
      step_max = 64'd1 << 25;
    end else begin
      v        = longint'($urandom_range(0, 2097152)) - 1048576;
      step_max = 64'd1 << 16;
    end
    for (int s = 0; s <= MaxBins; s++) begin
      if (wide && s == MaxBins) v = 64'sd2147483647;
      issue(OP_LOAD, ax, s, v[CoordBits-1:0], $urandom, $urandom, $urandom);
      if ($urandom_range(7) != 0) v += longint'($urandom_range(1, 32'(step_max)));
    end
  endtask

  function automatic logic [CoordBits-1:0] pick_coord(input int ax);
    int nb;
    int k;
    nb = (bins_set[ax] == '0) ? 1 : ((bins_set[ax] > MaxBins) ? MaxBins : int'(bins_set[ax]));
    k  = $urandom_range(0, nb);
    case ($urandom_range(9))
      0, 1, 2: return edge_mem[ax][k];
      3:       return edge_mem[ax][k] + 1;
      4:       return edge_mem[ax][k] - 1;
      5:       return edge_mem[ax][0] - 1;
      6:       return edge_mem[ax][nb] + 1;
      7:       return $urandom_range(1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
      8:       return 32'((longint'(edge_mem[ax][k]) +
                           longint'(edge_mem[ax][(k < MaxBins) ? k + 1 : k])) >>> 1);
      default: return $urandom;
    endcase
  endfunction

  initial begin
    int          ax;
    int          slot;
    int unsigned r;
    rst_ni       = 1'b0;
    start_i      = 1'b0;
    opcode_i     = OP_LOAD;
    axis_sel_i   = '0;
    edge_slot_i  = '0;
    edge_value_i = '0;
    coord_x_i    = '0;
    coord_y_i    = '0;
    coord_z_i    = '0;
    cfg_we_i     = 1'b0;
    cfg_idx_i    = CFG_FLOW_MODE;
    cfg_wdata_i  = '0;
    idle_pct     = 0;
    for (int a = 0; a < MaxAxes; a++) bins_set[a] = CfgDataW'(1);
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // every edge slot is written before any lookup can read it
    fill_axis(0, 1'b1);
    fill_axis(1, 1'b0);
    fill_axis(2, 1'b0);

    // outer-edge hits, extremes, underflow and overflow, several faulting axes
    for (int pass = 0; pass < 2; pass++) begin
      set_config(pass ? 3 : 0, pass, 3, 4, 4, 4);
      issue(OP_LOOKUP, 0, 0, $urandom, edge_mem[0][0], edge_mem[1][2], edge_mem[2][4]);
      issue(OP_LOOKUP, 0, 0, $urandom, 32'h8000_0000, edge_mem[1][1] + 1, 32'h7FFF_FFFF);
      issue(OP_LOOKUP, 0, 0, $urandom, 32'h7FFF_FFFF, edge_mem[1][3], edge_mem[2][0]);
      issue(OP_LOOKUP, 0, 0, $urandom, edge_mem[0][1], edge_mem[1][0] - 1,
            edge_mem[2][4] + 1);
      issue(OP_LOOKUP, 0, 0, $urandom, edge_mem[0][2] - 1, edge_mem[1][4] + 1,
            edge_mem[2][0] - 1);
    end
    issue(OP_LOAD, 3, 5, $urandom, $urandom, $urandom, $urandom);
    issue(OP_LOAD, 1, 65, $urandom, $urandom, $urandom, $urandom);
    issue(OP_LOAD, 0, 127, $urandom, $urandom, $urandom, $urandom);
    issue(OP_LOAD, 2, 0, 32'h8000_0000, $urandom, $urandom, $urandom);
    issue(OP_LOAD, 2, 4, 32'h7FFF_FFFF, $urandom, $urandom, $urandom);
    issue(OP_LOOKUP, 0, 0, $urandom, edge_mem[0][1], edge_mem[1][1], 32'h8000_0000);
    issue(OP_LOOKUP, 0, 0, $urandom, edge_mem[0][1], edge_mem[1][1], 32'h7FFF_FFFF);

    for (int p = 0; p < NumPhases; p++) begin
      case (p % 3)
        0:       idle_pct = 0;
        1:       idle_pct = 68;
        default: idle_pct = 24;
      endcase
      case (p)
        0: set_config(0, 0, 1, 64, 1, 1);
        1: set_config(3, 1, 3, 64, 64, 64);
        2: set_config(1, 0, 2, 1, 1, 1);
        3: set_config(2, 1, 3, 0, 127, 100);
        4: set_config($urandom_range(3), $urandom_range(1), 0, $urandom_range(1, 64),
                      $urandom_range(1, 64), $urandom_range(1, 64));
        default: set_config($urandom_range(3), $urandom_range(1), $urandom_range(3),
                            $urandom_range(9) < 7 ? $urandom_range(1, 64) : $urandom_range(127),
                            $urandom_range(9) < 7 ? $urandom_range(1, 64) : $urandom_range(127),
                            $urandom_range(9) < 7 ? $urandom_range(1, 64) : $urandom_range(127));
      endcase
      if (p > 0 && $urandom_range(2) == 0) fill_axis($urandom_range(2), $urandom_range(1));
      for (int i = 0; i < PhaseItems; i++) begin
        if (p == 5 && i == PhaseItems / 2) drain();
        r = $urandom_range(99);
        if (r < 12) begin
          ax   = $urandom_range(2);
          slot = $urandom_range(MaxBins);
          issue(OP_LOAD, ax, slot,
                $urandom_range(1) ? $urandom :
                  32'(longint'(edge_mem[ax][slot]) + longint'($urandom_range(131072)) - 65536),
                $urandom, $urandom, $urandom);
        end else if (r < 16) begin
          // out-of-range loads are dropped by the block
          if ($urandom_range(1)) issue(OP_LOAD, 3, $urandom_range(127), $urandom, $urandom,
                                       $urandom, $urandom);
          else issue(OP_LOAD, $urandom_range(3), $urandom_range(MaxBins + 1, 127), $urandom,
                     $urandom, $urandom, $urandom);
        end else begin
          issue(OP_LOOKUP, $urandom_range(3), $urandom_range(127), $urandom,
                pick_coord(0), pick_coord(1), pick_coord(2));
        end
      end
    end

    @(negedge clk_i);
    start_i <= 1'b0;
    while (outstanding != 0) @(negedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
